// ===== rtl/plh_pkg.sv =====
// Package for the polyline arc length and heading block.
// Holds widths, CORDIC constants, the arctangent table and the stage types.
// No dependencies.
`default_nettype none

package plh_pkg;

    // Default micro-rotation count (at most 32, the size of the arctangent table)
    localparam int unsigned PLH_CORDIC_STEPS = 16;

    // Field widths
    localparam int unsigned COORD_W = 32;
    localparam int unsigned DELTA_W = COORD_W + 1;
    localparam int unsigned GUARD_W = 8;
    // Rotation datapath: scaled deltas grow by the CORDIC gain, plus sign and margin
    localparam int unsigned CORDIC_W = DELTA_W + GUARD_W + 3;
    localparam int unsigned ANGLE_W = 32;
    localparam int unsigned HEAD_W = 16;
    localparam int unsigned LEN_W = 40;
    localparam int unsigned SEG_W = 37;

    localparam logic [LEN_W-1:0]   LEN_MAX   = {LEN_W{1'b1}};
    localparam logic [31:0]        INV_GAIN  = 32'd2608131496;
    localparam logic [ANGLE_W-1:0] ANGLE_PI  = 32'h8000_0000;

    // atan(2^-i) in units of 2^-32 turn
    localparam logic [ANGLE_W-1:0] ATAN_TABLE [32] = '{
        32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756,
        32'd42667331,  32'd21354465,  32'd10679838,  32'd5340245,
        32'd2670163,   32'd1335087,   32'd667544,    32'd333772,
        32'd166886,    32'd83443,     32'd41722,     32'd20861,
        32'd10430,     32'd5215,      32'd2608,      32'd1304,
        32'd652,       32'd326,       32'd163,       32'd81,
        32'd41,        32'd20,        32'd10,        32'd5,
        32'd3,         32'd1,         32'd1,         32'd0
    };

    // Vector handed from cell to cell along the rotation chain
    typedef struct packed {
        logic                valid;
        logic                first;
        logic                zero;
        logic [CORDIC_W-1:0] x;
        logic [CORDIC_W-1:0] y;
        logic [ANGLE_W-1:0]  z;
    } plh_vec_t;

    // Segment result after gain compensation
    typedef struct packed {
        logic              valid;
        logic              first;
        logic [HEAD_W-1:0] heading;
        logic [SEG_W-1:0]  seg;
    } plh_res_t;

endpackage

`default_nettype wire

// ===== rtl/plh_cordic_cell.sv =====
// One CORDIC vectoring micro-rotation cell with a fixed shift of STAGE.
// Depends on plh_pkg (vector type, arctangent table).
`default_nettype none

module plh_cordic_cell #(
    parameter int unsigned STAGE = 0
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             en,
    input  wire plh_pkg::plh_vec_t vec_in,
    output plh_pkg::plh_vec_t      vec_out
);
    import plh_pkg::*;

    logic                valid_reg;
    plh_vec_t            data_reg;
    plh_vec_t            data_next;
    logic [CORDIC_W-1:0] x_sh;
    logic [CORDIC_W-1:0] y_sh;

    // Rotate toward the x axis, direction from the sign of y
    always_comb
    begin
        x_sh = CORDIC_W'($signed(vec_in.x) >>> STAGE);
        y_sh = CORDIC_W'($signed(vec_in.y) >>> STAGE);
        data_next = vec_in;
        if (!vec_in.y[CORDIC_W-1])
        begin
            data_next.x = vec_in.x + y_sh;
            data_next.y = vec_in.y - x_sh;
            data_next.z = vec_in.z + ATAN_TABLE[STAGE[4:0]];
        end
        else
        begin
            data_next.x = vec_in.x - y_sh;
            data_next.y = vec_in.y + x_sh;
            data_next.z = vec_in.z - ATAN_TABLE[STAGE[4:0]];
        end
    end

    // Advance the token
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (en)
        begin
            valid_reg <= vec_in.valid;
        end
    end

    // Advance the payload
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            data_reg <= data_next;
        end
    end

    always_comb
    begin
        vec_out       = data_reg;
        vec_out.valid = valid_reg;
    end

endmodule

`default_nettype wire

// ===== rtl/plh_gain.sv =====
// Two-stage CORDIC gain compensation and heading rounding.
// Depends on plh_pkg (vector and result types, inverse gain constant).
`default_nettype none

module plh_gain (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              en,
    input  wire plh_pkg::plh_vec_t vec_in,
    output plh_pkg::plh_res_t      res_out
);
    import plh_pkg::*;

    localparam int unsigned MAG_W  = CORDIC_W - 1;
    localparam int unsigned HI_W   = MAG_W - 16;
    localparam int unsigned PHI_W  = HI_W + 32;
    localparam int unsigned PLO_W  = 16 + 32;
    localparam int unsigned T_W    = PHI_W + 1;
    localparam int unsigned RND_W  = T_W + 1;

    logic [MAG_W-1:0]   mag;
    logic [PHI_W-1:0]   p_hi_reg;
    logic [PLO_W-1:0]   p_lo_reg;
    logic               a_valid_reg;
    logic               a_first_reg;
    logic               a_zero_reg;
    logic [ANGLE_W-1:0] a_z_reg;
    logic [PLO_W:0]     lo_rnd;
    logic [T_W-1:0]     t_sum;
    logic [RND_W-1:0]   t_rnd;
    logic [ANGLE_W-1:0] z_rnd;
    logic               b_valid_reg;
    plh_res_t           b_data_reg;
    plh_res_t           b_data_next;

    // Clamp a negative magnitude to zero
    assign mag = vec_in.x[CORDIC_W-1] ? '0 : vec_in.x[MAG_W-1:0];

    // Stage A: split multiply by the inverse gain
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            p_hi_reg    <= PHI_W'(mag[MAG_W-1:16]) * PHI_W'(INV_GAIN);
            p_lo_reg    <= PLO_W'(mag[15:0]) * PLO_W'(INV_GAIN);
            a_first_reg <= vec_in.first;
            a_zero_reg  <= vec_in.zero;
            a_z_reg     <= vec_in.z;
        end
    end

    // Stage B: round the partial products and the angle
    always_comb
    begin
        lo_rnd = {1'b0, p_lo_reg} + (PLO_W+1)'(32'h8000);
        t_sum  = T_W'(p_hi_reg) + T_W'(lo_rnd[PLO_W:16]);
        t_rnd  = RND_W'(t_sum) + (RND_W'(1) << (15 + GUARD_W));
        z_rnd  = a_z_reg + ANGLE_W'(32'h8000);
        b_data_next       = '0;
        b_data_next.first = a_first_reg;
        if (!a_zero_reg && !a_first_reg)
        begin
            b_data_next.heading = z_rnd[ANGLE_W-1:ANGLE_W-HEAD_W];
            b_data_next.seg     = t_rnd[16+GUARD_W +: SEG_W];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            b_data_reg <= b_data_next;
        end
    end

    // Advance the tokens
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            a_valid_reg <= vec_in.valid;
            b_valid_reg <= a_valid_reg;
        end
    end

    always_comb
    begin
        res_out       = b_data_reg;
        res_out.valid = b_valid_reg;
    end

endmodule

`default_nettype wire

// ===== rtl/polyline_arc_length_heading.sv =====
// Polyline arc length and heading: top level with delta stage, CORDIC cell
// chain, gain compensation and length accumulator. Depends on plh_pkg,
// plh_cordic_cell and plh_gain.
//
// Each accepted point (x, y) gives one result: the heading from the previous
// point as a 16-bit binary angle (32768 = pi) and the running path length of
// the line, saturating at 2^40 - 1 with length_saturated set. A point with
// line_start, or the first point after reset, gives heading 0 and length 0.
// The block holds one point at a time. A transaction travels through a delta
// stage, a chain of CORDIC_STEPS rotation cells, two gain compensation stages
// and the accumulator before the next point is accepted. A finished result
// waits in the output register while the next point is already taken in.
`default_nettype none

module polyline_arc_length_heading #(
    parameter int unsigned CORDIC_STEPS = plh_pkg::PLH_CORDIC_STEPS
) (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         in_valid,
    output logic                              in_ready,
    input  wire logic [plh_pkg::COORD_W-1:0]  point_x,
    input  wire logic [plh_pkg::COORD_W-1:0]  point_y,
    input  wire logic                         line_start,
    output logic                              out_valid,
    input  wire logic                         out_ready,
    output logic [plh_pkg::HEAD_W-1:0]        heading,
    output logic [plh_pkg::LEN_W-1:0]         arc_length,
    output logic                              length_saturated
);
    import plh_pkg::*;

    logic                busy_reg;
    logic                have_prev_reg;
    logic [COORD_W-1:0]  last_x_reg;
    logic [COORD_W-1:0]  last_y_reg;
    logic                accept;
    logic                en;
    logic                load;
    logic [DELTA_W-1:0]  dx;
    logic [DELTA_W-1:0]  dy;
    logic [DELTA_W-1:0]  xr;
    logic [DELTA_W-1:0]  yr;
    logic                entry_valid_reg;
    plh_vec_t            entry_reg;
    plh_vec_t            entry_next;
    plh_vec_t            chain [CORDIC_STEPS+1];
    plh_res_t            tail;
    logic [LEN_W-1:0]    running_reg;
    logic [LEN_W-1:0]    running_next;
    logic [LEN_W:0]      len_sum;
    logic                out_valid_reg;
    logic [HEAD_W-1:0]   heading_reg;
    logic                sat_reg;

    assign in_ready = !busy_reg;
    assign accept   = in_valid && in_ready;
    // Hold the whole chain while a result waits for an occupied output
    assign en       = !(tail.valid && out_valid_reg && !out_ready);
    assign load     = tail.valid && en;

    // Form deltas and pre-rotate into the right half plane
    always_comb
    begin
        dx = {point_x[COORD_W-1], point_x} - {last_x_reg[COORD_W-1], last_x_reg};
        dy = {point_y[COORD_W-1], point_y} - {last_y_reg[COORD_W-1], last_y_reg};
        xr = dx[DELTA_W-1] ? (~dx + DELTA_W'(1)) : dx;
        yr = dx[DELTA_W-1] ? (~dy + DELTA_W'(1)) : dy;
        entry_next       = '0;
        entry_next.first = line_start || !have_prev_reg;
        entry_next.zero  = (dx == '0) && (dy == '0);
        entry_next.x     = {{(CORDIC_W-DELTA_W-GUARD_W){xr[DELTA_W-1]}}, xr, {GUARD_W{1'b0}}};
        entry_next.y     = {{(CORDIC_W-DELTA_W-GUARD_W){yr[DELTA_W-1]}}, yr, {GUARD_W{1'b0}}};
        entry_next.z     = dx[DELTA_W-1] ? ANGLE_PI : '0;
    end

    // Capture the point and track the previous one
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg        <= 1'b0;
            have_prev_reg   <= 1'b0;
            last_x_reg      <= '0;
            last_y_reg      <= '0;
            entry_valid_reg <= 1'b0;
        end
        else
        begin
            entry_valid_reg <= accept;
            if (accept)
            begin
                busy_reg      <= 1'b1;
                have_prev_reg <= 1'b1;
                last_x_reg    <= point_x;
                last_y_reg    <= point_y;
            end
            else if (load)
            begin
                busy_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            entry_reg <= entry_next;
        end
    end

    always_comb
    begin
        chain[0]       = entry_reg;
        chain[0].valid = entry_valid_reg;
    end

    // Rotation chain, one cell per micro-rotation
    for (genvar i = 0; i < CORDIC_STEPS; i++)
    begin : g_cell
        plh_cordic_cell #(
            .STAGE (i)
        ) u_cell (
            .clk     (clk),
            .rst_n   (rst_n),
            .en      (en),
            .vec_in  (chain[i]),
            .vec_out (chain[i+1])
        );
    end

    plh_gain u_gain (
        .clk     (clk),
        .rst_n   (rst_n),
        .en      (en),
        .vec_in  (chain[CORDIC_STEPS]),
        .res_out (tail)
    );

    // Accumulate the segment, restart at a line start and clamp at the maximum
    always_comb
    begin
        len_sum      = {1'b0, running_reg} + (LEN_W+1)'(tail.seg);
        running_next = running_reg;
        if (tail.first)
        begin
            running_next = '0;
        end
        else if (len_sum[LEN_W])
        begin
            running_next = LEN_MAX;
        end
        else
        begin
            running_next = len_sum[LEN_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            running_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else if (load)
        begin
            running_reg   <= running_next;
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            heading_reg <= tail.heading;
            sat_reg     <= (running_next == LEN_MAX);
        end
    end

    assign out_valid        = out_valid_reg;
    assign heading          = heading_reg;
    assign arc_length       = running_reg;
    assign length_saturated = sat_reg;

endmodule

`default_nettype wire

// ===== rtl/plh_checker.sv =====
// Port-level checker for polyline_arc_length_heading, bound to the top level.
// Depends on plh_pkg (field widths, length maximum).
`default_nettype none

module plh_checker (
    input wire logic                         clk,
    input wire logic                         rst_n,
    input wire logic                         in_valid,
    input wire logic                         in_ready,
    input wire logic [plh_pkg::COORD_W-1:0]  point_x,
    input wire logic [plh_pkg::COORD_W-1:0]  point_y,
    input wire logic                         line_start,
    input wire logic                         out_valid,
    input wire logic                         out_ready,
    input wire logic [plh_pkg::HEAD_W-1:0]   heading,
    input wire logic [plh_pkg::LEN_W-1:0]    arc_length,
    input wire logic                         length_saturated
);
    import plh_pkg::*;

    logic             seen_reg;
    logic [1:0]       first_q_reg;
    logic [1:0]       first_q_next;
    logic [1:0]       count_reg;
    logic [1:0]       count_next;
    logic             in_first;
    logic [LEN_W-1:0] last_len_reg;
    logic             in_xfer;
    logic             out_xfer;

    assign in_xfer  = in_valid && in_ready;
    assign out_xfer = out_valid && out_ready;
    assign in_first = line_start || !seen_reg;

    // Queue the line-open flag of each transaction in flight, oldest in bit 0
    always_comb
    begin
        first_q_next = first_q_reg;
        count_next   = count_reg;
        if (out_xfer)
        begin
            first_q_next = {1'b0, first_q_reg[1]};
            count_next   = count_reg - 2'd1;
        end
        if (in_xfer)
        begin
            first_q_next[count_next[0]] = in_first;
            count_next                  = count_next + 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seen_reg     <= 1'b0;
            first_q_reg  <= '0;
            count_reg    <= '0;
            last_len_reg <= '0;
        end
        else
        begin
            first_q_reg <= first_q_next;
            count_reg   <= count_next;
            if (in_xfer)
            begin
                seen_reg <= 1'b1;
            end
            if (out_xfer)
            begin
                last_len_reg <= arc_length;
            end
        end
    end

    // Hold a stalled result
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(arc_length) && $stable(heading))
        else $error("result changed while stalled");

    // Flag saturation exactly at the maximum length
    a_sat_flag: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (length_saturated == (arc_length == LEN_MAX)))
        else $error("length_saturated disagrees with arc_length");

    // Take one point at a time
    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        in_xfer |=> !in_ready)
        else $error("second transaction accepted while busy");

    // Open a line with zero heading and zero length
    a_line_open: assert property (@(posedge clk) disable iff (!rst_n)
        out_xfer && first_q_reg[0] |-> arc_length == '0 && heading == '0)
        else $error("first point of a line gave nonzero result");

    // Never shrink the length within a line
    a_monotone: assert property (@(posedge clk) disable iff (!rst_n)
        out_xfer && !first_q_reg[0] |-> arc_length >= last_len_reg)
        else $error("arc length decreased within a line");

endmodule

bind polyline_arc_length_heading plh_checker u_plh_checker (.*);

`default_nettype wire

// ===== bench/testbench.sv =====
// Self-checking bench for polyline_arc_length_heading: directed and random path points.
// Predicts heading and accumulated arc length with its own CORDIC model.
// Depends on plh_pkg and the polyline_arc_length_heading RTL.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int STEPS = plh_pkg::PLH_CORDIC_STEPS;
    localparam longint unsigned GAIN_COMP_Q32 = 64'd2608131496;
    localparam longint unsigned LEN_LIMIT = 64'hFF_FFFF_FFFF;
    localparam int STALL_LIMIT = 4000;
    localparam int HOLD_OFF_CYCLES = 400;
    localparam logic [31:0] COORD_MIN = 32'h8000_0000;
    localparam logic [31:0] COORD_MAX = 32'h7FFF_FFFF;

    typedef struct {
        logic [15:0] heading;
        logic [39:0] arc_length;
        logic        length_saturated;
    } path_result_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_ready;
    logic [31:0] point_x = '0;
    logic [31:0] point_y = '0;
    logic        line_start = 1'b0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    logic [15:0] heading;
    logic [39:0] arc_length;
    logic        length_saturated;

    // Predictor state
    logic [31:0]     prev_x = '0;
    logic [31:0]     prev_y = '0;
    longint unsigned path_len = 0;
    bit              have_prev = 1'b0;

    path_result_t pending_path_results[$];
    path_result_t oldest_result;
    int           mismatch_count = 0;
    int           stall_cycles = 0;
    int           send_idle_pct = 0;
    int           recv_stall_pct = 0;
    int           hold_left = 0;

    polyline_arc_length_heading #(
        .CORDIC_STEPS(STEPS)
    ) i_dut (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_ready(in_ready),
        .point_x(point_x),
        .point_y(point_y),
        .line_start(line_start),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .heading(heading),
        .arc_length(arc_length),
        .length_saturated(length_saturated)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // atan(2^-i) in units of 2^-32 turn
    function automatic logic [31:0] atan_step(int i);
        case (i)
            0: atan_step = 32'd536870912;
            1: atan_step = 32'd316933406;
            2: atan_step = 32'd167458907;
            3: atan_step = 32'd85004756;
            4: atan_step = 32'd42667331;
            5: atan_step = 32'd21354465;
            6: atan_step = 32'd10679838;
            7: atan_step = 32'd5340245;
            8: atan_step = 32'd2670163;
            9: atan_step = 32'd1335087;
            10: atan_step = 32'd667544;
            11: atan_step = 32'd333772;
            12: atan_step = 32'd166886;
            13: atan_step = 32'd83443;
            14: atan_step = 32'd41722;
            15: atan_step = 32'd20861;
            16: atan_step = 32'd10430;
            17: atan_step = 32'd5215;
            18: atan_step = 32'd2608;
            19: atan_step = 32'd1304;
            20: atan_step = 32'd652;
            21: atan_step = 32'd326;
            22: atan_step = 32'd163;
            23: atan_step = 32'd81;
            24: atan_step = 32'd41;
            25: atan_step = 32'd20;
            26: atan_step = 32'd10;
            27: atan_step = 32'd5;
            28: atan_step = 32'd3;
            29: atan_step = 32'd1;
            30: atan_step = 32'd1;
            default: atan_step = 32'd0;
        endcase
    endfunction

    // Vector one segment: angle in 2^-32 turn, gain-compensated length
    function automatic void segment_vector(input longint dx, input longint dy,
                                           output logic [31:0] ang,
                                           output longint unsigned seg);
        longint          x;
        longint          y;
        longint          nx;
        logic [31:0]     z;
        longint unsigned mag;
        longint unsigned hi;
        longint unsigned lo;
        longint unsigned t;
        ang = '0;
        seg = 0;
        if (dx == 0 && dy == 0)
        begin
            return;
        end
        x = dx;
        y = dy;
        z = '0;
        // Pre-rotate the left half-plane by pi
        if (x < 0)
        begin
            x = -x;
            y = -y;
            z = 32'h8000_0000;
        end
        x = x * 256;
        y = y * 256;
        for (int i = 0; i < STEPS && i < 32; i++)
        begin
            if (y >= 0)
            begin
                nx = x + (y >>> i);
                y = y - (x >>> i);
                z = z + atan_step(i);
            end
            else
            begin
                nx = x - (y >>> i);
                y = y + (x >>> i);
                z = z - atan_step(i);
            end
            x = nx;
        end
        // Remove the CORDIC gain with a split multiply and drop the guard bits
        mag = (x > 0) ? x : 0;
        hi = mag >> 16;
        lo = mag & 64'hFFFF;
        t = hi * GAIN_COMP_Q32 + ((lo * GAIN_COMP_Q32 + 64'h8000) >> 16);
        seg = (t + (64'd1 << 23)) >> 24;
        ang = z;
    endfunction

    // Advance the path state by one point and return the result it causes
    function automatic path_result_t predict_path_point(logic [31:0] px, logic [31:0] py,
                                                        logic start);
        path_result_t    r;
        longint          sx;
        longint          sy;
        longint          lx;
        longint          ly;
        logic [31:0]     ang;
        logic [31:0]     rounded;
        longint unsigned seg;
        longint unsigned sum;
        r.heading = '0;
        if (start || !have_prev)
        begin
            path_len = 0;
        end
        else
        begin
            sx = $signed(px);
            sy = $signed(py);
            lx = $signed(prev_x);
            ly = $signed(prev_y);
            segment_vector(sx - lx, sy - ly, ang, seg);
            sum = path_len + seg;
            path_len = (sum > LEN_LIMIT) ? LEN_LIMIT : sum;
            rounded = ang + 32'h0000_8000;
            r.heading = rounded[31:16];
        end
        prev_x = px;
        prev_y = py;
        have_prev = 1'b1;
        r.arc_length = path_len[39:0];
        r.length_saturated = (path_len == LEN_LIMIT);
        return r;
    endfunction

    task automatic flag_mismatch(input string what, input longint unsigned got,
                                 input longint unsigned want);
        mismatch_count++;
        $display("mismatch at %0t: %s got %0d want %0d", $realtime, what, got, want);
    endtask

    // Offer one point, hold it until accepted, record its expected result
    task automatic send_point(input logic [31:0] px, input logic [31:0] py,
                              input logic start);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid = 1'b0;
            @(negedge clk);
        end
        in_valid = 1'b1;
        point_x = px;
        point_y = py;
        line_start = start;
        do
            @(posedge clk);
        while (!in_ready);
        pending_path_results.insert(pending_path_results.size(),
                                    predict_path_point(px, py, start));
        @(negedge clk);
    endtask

    // Drop valid and hold until every outstanding transaction has returned
    task automatic wait_for_results();
        in_valid = 1'b0;
        while (pending_path_results.size() != 0)
        begin
            @(negedge clk);
        end
    endtask

    task automatic set_idling(input int send_pct, input int recv_pct);
        send_idle_pct = send_pct;
        recv_stall_pct = recv_pct;
    endtask

    // First point after reset, repeated points and the four axis headings
    task automatic test_first_and_repeat();
        send_point(32'd0, 32'd0, 1'b0);
        send_point(32'd0, 32'd0, 1'b0);
        send_point(32'd256, 32'd0, 1'b0);
        send_point(32'd256, 32'd256, 1'b0);
        send_point(32'd0, 32'd256, 1'b0);
        send_point(32'd0, 32'd0, 1'b0);
        send_point(32'd1, 32'd1, 1'b0);
        send_point(32'd1, 32'd1, 1'b0);
    endtask

    // Largest deltas along both diagonals and the x axis
    task automatic test_extreme_deltas();
        send_point(COORD_MIN, COORD_MIN, 1'b1);
        send_point(COORD_MAX, COORD_MAX, 1'b0);
        send_point(COORD_MIN, COORD_MIN, 1'b0);
        send_point(COORD_MAX, COORD_MIN, 1'b0);
        send_point(COORD_MIN, COORD_MAX, 1'b0);
        send_point(COORD_MAX, COORD_MAX, 1'b0);
        send_point(32'hFFFF_FFFF, 32'd0, 1'b0);
    endtask

    // Line starts in a row and in the middle of a line
    task automatic test_line_starts();
        send_point(32'd100, 32'd200, 1'b1);
        send_point(32'd300, -32'sd50, 1'b1);
        send_point(32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0);
        send_point(32'd5, -32'sd3, 1'b1);
        send_point(32'd6, -32'sd3, 1'b0);
    endtask

    // Mostly well-formed lines of random walks, some full-range noise
    task automatic test_random_lines(input int count);
        int          sent;
        int          points;
        logic [31:0] cx;
        logic [31:0] cy;
        logic [31:0] step_x;
        logic [31:0] step_y;
        sent = 0;
        while (sent < count)
        begin
            if ($urandom_range(9) < 8)
            begin
                cx = $urandom;
                cy = $urandom;
                send_point(cx, cy, 1'b1);
                sent++;
                points = $urandom_range(1, 30);
                repeat (points)
                begin
                    step_x = $signed($urandom) >>> $urandom_range(31);
                    step_y = $signed($urandom) >>> $urandom_range(31);
                    // Hold the point now and then to produce a zero delta
                    if ($urandom_range(15) != 0)
                    begin
                        cx = cx + step_x;
                        cy = cy + step_y;
                    end
                    send_point(cx, cy, 1'b0);
                    sent++;
                end
            end
            else
            begin
                send_point($urandom, $urandom, 1'(($urandom_range(1))));
                sent++;
            end
        end
    endtask

    // Bounce between opposite corners until the length clamps, then clear it
    task automatic test_length_saturation();
        send_point(COORD_MIN, COORD_MIN, 1'b1);
        for (int i = 0; i < 200; i++)
        begin
            if (i % 2 == 0)
            begin
                send_point(COORD_MAX - $urandom_range(255), COORD_MAX - $urandom_range(255),
                           1'b0);
            end
            else
            begin
                send_point(COORD_MIN + $urandom_range(255), COORD_MIN + $urandom_range(255),
                           1'b0);
            end
        end
        send_point(point_x, point_y, 1'b0);
        send_point(32'd0, 32'd0, 1'b1);
        send_point(32'd512, 32'd512, 1'b0);
    endtask

    // Hold off the receiver while the sender keeps offering, then pause the sender
    task automatic test_backpressure();
        set_idling(0, 0);
        hold_left = HOLD_OFF_CYCLES;
        repeat (12)
        begin
            send_point($urandom, $urandom, 1'(($urandom_range(1))));
        end
        wait_for_results();
        repeat (12)
        begin
            send_point($urandom, $urandom, 1'b0);
        end
    endtask

    // Drive the receiver ready, honoring a requested hold-off
    always @(negedge clk)
    begin
        if (hold_left > 0)
        begin
            out_ready = 1'b0;
            hold_left--;
        end
        else
        begin
            out_ready = ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // Compare each returned transaction with the oldest prediction
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_path_results.size() == 0)
            begin
                flag_mismatch("unexpected result, arc_length", arc_length, 0);
            end
            else
            begin
                oldest_result = pending_path_results.pop_front();
                if (heading !== oldest_result.heading)
                    flag_mismatch("heading", heading, oldest_result.heading);
                if (arc_length !== oldest_result.arc_length)
                    flag_mismatch("arc_length", arc_length, oldest_result.arc_length);
                if (length_saturated !== oldest_result.length_saturated)
                    flag_mismatch("length_saturated", length_saturated,
                                  oldest_result.length_saturated);
            end
        end
    end

    // End the run when no transaction moves for too long
    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready))
        begin
            stall_cycles = 0;
        end
        else
        begin
            stall_cycles++;
        end
        if (stall_cycles >= STALL_LIMIT)
        begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    initial
    begin
        repeat (2) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        set_idling(0, 0);
        test_first_and_repeat();
        test_extreme_deltas();
        test_line_starts();

        set_idling(0, 0);
        test_random_lines(120);
        set_idling(63, 0);
        test_random_lines(120);
        set_idling(0, 63);
        test_random_lines(120);
        set_idling(15, 15);
        test_random_lines(120);
        test_length_saturation();

        test_backpressure();

        wait_for_results();
        repeat (STEPS + 8) @(posedge clk);
        if (mismatch_count == 0 && pending_path_results.size() == 0)
        begin
            $display("SCOREBOARD CLEAN");
        end
        else
        begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end
endmodule

// ===== filelist.f =====
rtl/plh_pkg.sv
rtl/plh_cordic_cell.sv
rtl/plh_gain.sv
rtl/polyline_arc_length_heading.sv
rtl/plh_checker.sv
bench/testbench.sv
